>>> src/battery_charge_profile_limiter_macros.svh
// Assertion helpers for the checker of the charge profile limiter.
`ifndef BATTERY_CHARGE_PROFILE_LIMITER_MACROS_SVH
`define BATTERY_CHARGE_PROFILE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BCPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BCPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bcpl_pkg.sv
// ---------------------------------------------------------------------------
// bcpl_pkg
// Types, constants and table functions of the battery charge profile limiter.
// ---------------------------------------------------------------------------
package bcpl_pkg;

    localparam int ZONE_COUNT = 4;
    localparam int ZONE_SLOTS = 8;
    localparam int ZONE_N     = (ZONE_COUNT < 1) ? 1 :
                                ((ZONE_COUNT > ZONE_SLOTS) ? ZONE_SLOTS : ZONE_COUNT);
    localparam int ZONE_IDX_W = 3;

    localparam int CUR_W      = 12;
    localparam int VOLT_W     = 13;
    localparam int MIN_W      = 12;
    localparam int TEMP_C_W   = 17;
    localparam int DERATE_W   = 8;
    localparam int DIVIDEND_W = 23;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [TEMP_C_W-1:0] KELVIN_OFFSET = 17'sd2731;
    localparam logic [VOLT_W-1:0] VOLT_MAX = 13'd8191;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 12'd4095;

    // Input action codes.
    localparam logic ACT_EVAL = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Charge phase codes.
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DISCHARGE = 2'd1;
    localparam logic [1:0] PH_CHARGE    = 2'd2;
    localparam logic [1:0] PH_PRECHARGE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HOLD_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_HOLD_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_VOLT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_VOLT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_TEMP        = 3'd4;

    localparam logic [11:0] RST_CHARGE_HOLD_MIN = 12'd2880;
    localparam logic [11:0] RST_HOT_HOLD_MIN    = 12'd120;
    localparam logic [15:0] RST_HOLD_VOLT       = 16'd4250;
    localparam logic [15:0] RST_HOT_VOLT        = 16'd4100;
    localparam logic [9:0]  RST_HOT_TEMP        = 10'd450;

    typedef struct packed {
        logic [11:0] charge_hold_minutes;
        logic [11:0] hot_hold_minutes;
        logic [15:0] hold_voltage_mv;
        logic [15:0] hot_voltage_mv;
        logic [9:0]  hot_temp_decic;
    } t_cfg;

    // Fields of an evaluate request kept while the divider runs.
    typedef struct packed {
        logic [15:0] temperature_decik;
        logic        temp_bad;
        logic [1:0]  charge_phase;
        logic [15:0] charger_voltage_mv;
        logic [15:0] battery_voltage_mv;
        logic [15:0] cycles;
        logic        cycles_valid;
        logic [15:0] design_capacity_mah;
        logic        capacity_valid;
    } t_eval;

    typedef struct packed {
        logic [CUR_W-1:0]  current_ma;
        logic [VOLT_W-1:0] voltage_mv;
        logic              stop_charge;
    } t_result;

    function automatic logic signed [TEMP_C_W-1:0] zone_upper(
        input logic [ZONE_IDX_W-1:0] idx);
        case (idx)
            3'd0:    zone_upper = 17'sd150;
            3'd1:    zone_upper = 17'sd430;
            3'd2:    zone_upper = 17'sd450;
            default: zone_upper = 17'sd500;
        endcase
    endfunction

    function automatic logic [CUR_W-1:0] zone_current(input logic [ZONE_IDX_W-1:0] idx);
        case (idx)
            3'd0:    zone_current = 12'd1408;
            3'd1:    zone_current = 12'd3520;
            3'd2:    zone_current = 12'd2112;
            default: zone_current = 12'd1760;
        endcase
    endfunction

    function automatic logic [VOLT_W-1:0] zone_voltage(input logic [ZONE_IDX_W-1:0] idx);
        case (idx)
            3'd0:    zone_voltage = 13'd4370;
            3'd1:    zone_voltage = 13'd4370;
            3'd2:    zone_voltage = 13'd4320;
            default: zone_voltage = 13'd4170;
        endcase
    endfunction

    function automatic logic [DERATE_W-1:0] cycle_derate(input logic [15:0] c);
        if (c > 16'd1000)     cycle_derate = 8'd150;
        else if (c > 16'd600) cycle_derate = 8'd100;
        else if (c > 16'd300) cycle_derate = 8'd80;
        else if (c > 16'd50)  cycle_derate = 8'd65;
        else if (c > 16'd20)  cycle_derate = 8'd50;
        else                  cycle_derate = 8'd0;
    endfunction

    function automatic logic [DERATE_W-1:0] health_derate(
        input logic [DIVIDEND_W-1:0] h);
        if (h <= 23'd50)      health_derate = 8'd150;
        else if (h <= 23'd55) health_derate = 8'd100;
        else if (h <= 23'd60) health_derate = 8'd80;
        else if (h <= 23'd70) health_derate = 8'd65;
        else if (h <= 23'd75) health_derate = 8'd50;
        else                  health_derate = 8'd0;
    endfunction

    function automatic logic [VOLT_W-1:0] sat_volt(input logic [15:0] v);
        sat_volt = (v > {3'b000, VOLT_MAX}) ? VOLT_MAX : v[VOLT_W-1:0];
    endfunction

endpackage

>>> src/battery_charge_profile_limiter.sv
// ---------------------------------------------------------------------------
// battery_charge_profile_limiter
// Temperature-zoned charge current and voltage request with ageing derate
// and timed hold rules.
// ---------------------------------------------------------------------------
// Usage: a request on the input channel is either an evaluate (action 0),
// carrying one battery reading, or a one-minute tick (action 1). An evaluate
// returns one result (current, voltage, stop flag) on the output channel; a
// tick returns nothing and only advances the armed minute counters.
// A tick is absorbed without stalling the input and the next request may follow at once.
// An evaluate runs the state-of-health ratio through a bit-serial divider,
// one quotient bit per cycle, and the result is then committed to the output
// register; a new request is taken only after that commit, so evaluates do
// not overlap. o_in_stall stays high while an evaluate is in progress.
// The result sits in an output register; while the receiver stalls, a new
// evaluate still runs and waits at its end until that register is free.
// Reset (synchronous, active low) clears the hold and hot counters, returns
// the configuration registers to their defaults and empties the output.
// Configuration writes are registered and must be made while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module battery_charge_profile_limiter import bcpl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [15:0]           i_temperature_decik,
    input  logic                  i_temp_bad,
    input  logic [1:0]            i_charge_phase,
    input  logic [15:0]           i_charger_voltage_mv,
    input  logic [15:0]           i_battery_voltage_mv,
    input  logic [15:0]           i_cycles,
    input  logic                  i_cycles_valid,
    input  logic [15:0]           i_full_capacity_mah,
    input  logic [15:0]           i_design_capacity_mah,
    input  logic                  i_capacity_valid,
    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CUR_W-1:0]      o_current_ma,
    output logic [VOLT_W-1:0]     o_voltage_mv,
    output logic                  o_stop_charge
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            r_state, n_state;
    t_cfg                  r_cfg, n_cfg;
    t_eval                 r_eval, n_eval;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  in_accept;
    logic                  eval_start;
    logic                  tick;
    logic                  commit;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] health;
    t_result               res;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign eval_start = in_accept && (i_action == ACT_EVAL);
    assign tick       = in_accept && (i_action == ACT_TICK);
    assign commit     = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // full * 100 as shifted adds: 64 + 32 + 4.
    assign dividend = {1'b0, i_full_capacity_mah, 6'b0} +
                      {2'b0, i_full_capacity_mah, 5'b0} +
                      {5'b0, i_full_capacity_mah, 2'b0};

    bcpl_sohdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (eval_start),
        .i_dividend (dividend),
        .i_divisor  (i_design_capacity_mah),
        .o_done     (div_done),
        .o_quot     (health)
    );

    bcpl_rules u_rules (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_eval   (r_eval),
        .i_health (health),
        .i_commit (commit),
        .i_tick   (tick),
        .o_res    (res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (eval_start) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (commit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHARGE_HOLD_MIN: n_cfg.charge_hold_minutes = i_cfg_data[11:0];
                CFG_HOT_HOLD_MIN:    n_cfg.hot_hold_minutes    = i_cfg_data[11:0];
                CFG_HOLD_VOLT:       n_cfg.hold_voltage_mv     = i_cfg_data;
                CFG_HOT_VOLT:        n_cfg.hot_voltage_mv      = i_cfg_data;
                CFG_HOT_TEMP:        n_cfg.hot_temp_decic      = i_cfg_data[9:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_eval = r_eval;
        if (eval_start) begin
            n_eval.temperature_decik   = i_temperature_decik;
            n_eval.temp_bad            = i_temp_bad;
            n_eval.charge_phase        = i_charge_phase;
            n_eval.charger_voltage_mv  = i_charger_voltage_mv;
            n_eval.battery_voltage_mv  = i_battery_voltage_mv;
            n_eval.cycles              = i_cycles;
            n_eval.cycles_valid        = i_cycles_valid;
            n_eval.design_capacity_mah = i_design_capacity_mah;
            n_eval.capacity_valid      = i_capacity_valid;
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                 <= ST_IDLE;
            r_out_valid             <= 1'b0;
            r_cfg.charge_hold_minutes <= RST_CHARGE_HOLD_MIN;
            r_cfg.hot_hold_minutes    <= RST_HOT_HOLD_MIN;
            r_cfg.hold_voltage_mv     <= RST_HOLD_VOLT;
            r_cfg.hot_voltage_mv      <= RST_HOT_VOLT;
            r_cfg.hot_temp_decic      <= RST_HOT_TEMP;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval <= n_eval;
        r_out  <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_current_ma  = r_out.current_ma;
    assign o_voltage_mv  = r_out.voltage_mv;
    assign o_stop_charge = r_out.stop_charge;

endmodule

>>> src/bcpl_sohdiv.sv
// ---------------------------------------------------------------------------
// bcpl_sohdiv
// Bit-serial restoring divider for the state-of-health ratio, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module bcpl_sohdiv import bcpl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [15:0]           i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]           r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [15:0]           r_dsr, n_dsr;
    logic [16:0]           trial;
    logic [16:0]           diff;
    logic                  ge;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[15:0] : trial[15:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> src/bcpl_rules.sv
// ---------------------------------------------------------------------------
// bcpl_rules
// Temperature zone lookup, ageing derate and the two timed hold rules with
// their armed minute counters.
// ---------------------------------------------------------------------------
module bcpl_rules import bcpl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_eval                 i_eval,
    input  logic [DIVIDEND_W-1:0] i_health,
    input  logic                  i_commit,
    input  logic                  i_tick,
    output t_result               o_res
);

    logic             r_hold_armed, n_hold_armed;
    logic [MIN_W-1:0] r_hold_min, n_hold_min;
    logic             r_hot_armed, n_hot_armed;
    logic [MIN_W-1:0] r_hot_min, n_hot_min;

    logic signed [TEMP_C_W-1:0] temp_c;
    logic                       out_range;
    logic [ZONE_IDX_W-1:0]      zone;
    logic [1:0]                 phase;
    logic                       charging;
    logic [15:0]                cyc;
    logic                       health_zero;
    logic [DERATE_W-1:0]        d_cyc, d_soh, der;
    logic [VOLT_W-1:0]          volt_zone, volt_der, volt_hold;
    logic                       hold_clear, hot_clear;
    logic                       hold_force, hot_force;

    always_comb begin
        temp_c    = signed'({1'b0, i_eval.temperature_decik}) - KELVIN_OFFSET;
        out_range = i_eval.temp_bad || (temp_c < 0) ||
                    (temp_c >= zone_upper(ZONE_IDX_W'(ZONE_N - 1)));
        // Zone bounds rise monotonically, so the last bound passed picks the zone.
        zone = '0;
        for (int k = 0; k < ZONE_N - 1; k++) begin
            if (temp_c >= zone_upper(ZONE_IDX_W'(k))) zone = ZONE_IDX_W'(k + 1);
        end
        phase    = out_range ? PH_IDLE : i_eval.charge_phase;
        charging = (phase == PH_CHARGE) || (phase == PH_PRECHARGE);

        cyc         = i_eval.cycles_valid ? i_eval.cycles : 16'd0;
        health_zero = !i_eval.capacity_valid || (i_eval.design_capacity_mah == 16'd0);
        d_cyc       = cycle_derate(cyc);
        d_soh       = health_derate(health_zero ? '0 : i_health);
        der         = (d_cyc > d_soh) ? d_cyc : d_soh;

        volt_zone = out_range ? '0 : zone_voltage(zone);
        volt_der  = (volt_zone > {5'b0, der}) ? (volt_zone - {5'b0, der}) : '0;

        hold_clear = (phase == PH_DISCHARGE) ||
                     (i_eval.charger_voltage_mv < i_cfg.hold_voltage_mv);
        hot_clear  = (phase == PH_DISCHARGE) ||
                     (i_eval.battery_voltage_mv < i_cfg.hot_voltage_mv) ||
                     (temp_c < signed'({7'b0, i_cfg.hot_temp_decic}));
        hold_force = !hold_clear && charging && r_hold_armed &&
                     (r_hold_min >= i_cfg.charge_hold_minutes);
        hot_force  = !hot_clear && charging && r_hot_armed &&
                     (r_hot_min >= i_cfg.hot_hold_minutes);

        volt_hold         = hold_force ? sat_volt(i_cfg.hold_voltage_mv) : volt_der;
        o_res.voltage_mv  = hot_force ? sat_volt(i_cfg.hot_voltage_mv) : volt_hold;
        o_res.current_ma  = (out_range || hot_force) ? '0 : zone_current(zone);
        o_res.stop_charge = out_range;
    end

    always_comb begin
        n_hold_armed = r_hold_armed;
        n_hold_min   = r_hold_min;
        n_hot_armed  = r_hot_armed;
        n_hot_min    = r_hot_min;
        if (i_commit) begin
            if (hold_clear) begin
                n_hold_armed = 1'b0;
                n_hold_min   = '0;
            end else if (charging && !r_hold_armed) begin
                n_hold_armed = 1'b1;
                n_hold_min   = '0;
            end
            if (hot_clear) begin
                n_hot_armed = 1'b0;
                n_hot_min   = '0;
            end else if (charging && !r_hot_armed) begin
                n_hot_armed = 1'b1;
                n_hot_min   = '0;
            end
        end else if (i_tick) begin
            if (r_hold_armed && (r_hold_min != MIN_MAX)) n_hold_min = r_hold_min + 1'b1;
            if (r_hot_armed && (r_hot_min != MIN_MAX))   n_hot_min  = r_hot_min + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_armed <= 1'b0;
            r_hold_min   <= '0;
            r_hot_armed  <= 1'b0;
            r_hot_min    <= '0;
        end else begin
            r_hold_armed <= n_hold_armed;
            r_hold_min   <= n_hold_min;
            r_hot_armed  <= n_hot_armed;
            r_hot_min    <= n_hot_min;
        end
    end

endmodule

>>> src/bcpl_checker.sv
// ---------------------------------------------------------------------------
// bcpl_checker
// Port-level checks of the charge profile limiter, bound to the top level.
// ---------------------------------------------------------------------------
`include "battery_charge_profile_limiter_macros.svh"

module bcpl_checker import bcpl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_action,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CUR_W-1:0]  o_current_ma,
    input logic [VOLT_W-1:0] o_voltage_mv,
    input logic              o_stop_charge
);

    // A result held back by the receiver stays put.
    `BCPL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_current_ma) && $stable(o_voltage_mv) && $stable(o_stop_charge), "output result changed while stalled")

    // An accepted evaluate occupies the block for its division.
    `BCPL_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_action == ACT_EVAL), o_in_stall, "evaluate request did not hold off the input")

    // A stop result never requests any charge.
    `BCPL_ASSERT_NOW(a_stop_zero, i_clk, i_rst_n, o_out_valid && o_stop_charge, (o_current_ma == '0) && (o_voltage_mv == '0), "stop result with nonzero request")

    // No zone asks for more than the highest zone current.
    `BCPL_ASSERT_NOW(a_cur_max, i_clk, i_rst_n, o_out_valid, o_current_ma <= 12'd3520, "current above the zone maximum")

endmodule

bind battery_charge_profile_limiter bcpl_checker u_bcpl_checker (.*);
